>>> src/axis_min_max_calibration_tracker_unit_defines.svh
// Assertion macros for the min/max calibration tracker.
`ifndef AXIS_MIN_MAX_CALIBRATION_TRACKER_UNIT_DEFINES_SVH
`define AXIS_MIN_MAX_CALIBRATION_TRACKER_UNIT_DEFINES_SVH

// Same-cycle implication, disabled in reset.
`define MMCT_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled in reset.
`define MMCT_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

>>> src/mmct_pkg.sv
// Shared types and constants for the min/max calibration tracker.
package mmct_pkg;

  localparam int NUM_AXES = 3;
  localparam int SAMPLE_W = 16;
  localparam int RANGE_W  = 17;
  localparam int TIME_W   = 32;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;

  localparam logic [TIME_W-1:0]          TIMEOUT_RESET  = 32'd20000;
  localparam logic signed [SAMPLE_W-1:0] SEED_MIN_RESET = 16'sh7FFF;
  localparam logic signed [SAMPLE_W-1:0] SEED_MAX_RESET = 16'sh8000;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_TIMEOUT    = 3'd0,
    REG_SEED_MIN_X = 3'd1,
    REG_SEED_MAX_X = 3'd2,
    REG_SEED_MIN_Y = 3'd3,
    REG_SEED_MAX_Y = 3'd4,
    REG_SEED_MIN_Z = 3'd5,
    REG_SEED_MAX_Z = 3'd6
  } reg_idx_t;

  typedef logic signed [SAMPLE_W-1:0] sample_t;
  typedef logic signed [RANGE_W-1:0]  wide_t;

  // Registered input request.
  typedef struct packed {
    logic                start_req;
    sample_t             raw_x;
    sample_t             raw_y;
    sample_t             raw_z;
    logic [TIME_W-1:0]   now_ms;
  } in_req_t;

endpackage

>>> src/axis_min_max_calibration_tracker_unit.sv
// Three-axis min/max hard-iron calibration tracker, top level.
// Request path: input register, then bound update, then result register.
// Throughput: one request per cycle unless a held result (out_ready low) stalls the input.
// Reset (rst, sync, active high): timeout 20000, seeds and bounds at +32767/-32768,
// last change time 0, not finished, both pipeline registers empty.
`include "axis_min_max_calibration_tracker_unit_defines.svh"
module axis_min_max_calibration_tracker_unit
  import mmct_pkg::*;
(
  input  logic                         clk,
  input  logic                         rst,
  // input channel
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic                         start_req,
  input  logic signed [SAMPLE_W-1:0]   raw_x,
  input  logic signed [SAMPLE_W-1:0]   raw_y,
  input  logic signed [SAMPLE_W-1:0]   raw_z,
  input  logic [TIME_W-1:0]            now_ms,
  // result channel
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic                         done_res,
  output logic                         changed,
  output logic signed [SAMPLE_W-1:0]   offset_x,
  output logic signed [SAMPLE_W-1:0]   offset_y,
  output logic signed [SAMPLE_W-1:0]   offset_z,
  output logic signed [RANGE_W-1:0]    range_x,
  output logic signed [RANGE_W-1:0]    range_y,
  output logic signed [RANGE_W-1:0]    range_z,
  // configuration write port
  input  logic                         cfg_we,
  input  logic [CFG_IDX_W-1:0]         cfg_index,
  input  logic [CFG_DATA_W-1:0]        cfg_data
);

  // ---------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------
  logic [TIME_W-1:0] timeout_ms;
  sample_t           seed_min [NUM_AXES];
  sample_t           seed_max [NUM_AXES];

  always_ff @(posedge clk) begin
    if (rst) begin
      timeout_ms <= TIMEOUT_RESET;
      for (int a = 0; a < NUM_AXES; a++) begin
        seed_min[a] <= SEED_MIN_RESET;
        seed_max[a] <= SEED_MAX_RESET;
      end
    end else if (cfg_we) begin
      unique case (reg_idx_t'(cfg_index))
        REG_TIMEOUT:    timeout_ms  <= cfg_data[TIME_W-1:0];
        REG_SEED_MIN_X: seed_min[0] <= cfg_data[SAMPLE_W-1:0];
        REG_SEED_MAX_X: seed_max[0] <= cfg_data[SAMPLE_W-1:0];
        REG_SEED_MIN_Y: seed_min[1] <= cfg_data[SAMPLE_W-1:0];
        REG_SEED_MAX_Y: seed_max[1] <= cfg_data[SAMPLE_W-1:0];
        REG_SEED_MIN_Z: seed_min[2] <= cfg_data[SAMPLE_W-1:0];
        REG_SEED_MAX_Z: seed_max[2] <= cfg_data[SAMPLE_W-1:0];
        default: ;  // unused index, dropped
      endcase
    end
  end

  // ---------------------------------------------------------------
  // Pipeline handshake: input register -> update -> result register.
  // The update stage fires whenever the result register is free or
  // being drained, so while that holds a new request is taken every cycle.
  // ---------------------------------------------------------------
  logic    in_vld_q;
  in_req_t in_q;
  logic    adv;       // update stage moves a request into the result reg
  logic    fire;      // a real request is processed this cycle

  assign adv      = !out_valid || out_ready;
  assign in_ready = !in_vld_q || adv;
  assign fire     = in_vld_q && adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_vld_q <= 1'b0;
    end else if (in_ready) begin
      in_vld_q <= in_valid;
    end
    if (in_valid && in_ready) begin
      in_q <= '{start_req: start_req, raw_x: raw_x, raw_y: raw_y,
                raw_z: raw_z, now_ms: now_ms};
    end
  end

  // ---------------------------------------------------------------
  // Tracker state
  // ---------------------------------------------------------------
  sample_t           axis_min [NUM_AXES];
  sample_t           axis_max [NUM_AXES];
  logic [TIME_W-1:0] last_change_ms;
  logic              finished;

  sample_t           axis_min_next [NUM_AXES];
  sample_t           axis_max_next [NUM_AXES];
  logic [TIME_W-1:0] last_change_ms_next;
  logic              finished_next;
  logic              widened;

  // effective state after an optional start reload
  sample_t           base_min [NUM_AXES];
  sample_t           base_max [NUM_AXES];
  logic [TIME_W-1:0] base_last;
  logic              base_fin;
  sample_t           smp [NUM_AXES];
  logic [TIME_W-1:0] elapsed;

  assign smp[0] = in_q.raw_x;
  assign smp[1] = in_q.raw_y;
  assign smp[2] = in_q.raw_z;

  always_comb begin
    base_last = in_q.start_req ? '0   : last_change_ms;
    base_fin  = in_q.start_req ? 1'b0 : finished;
    widened   = 1'b0;
    for (int a = 0; a < NUM_AXES; a++) begin
      base_min[a]      = in_q.start_req ? seed_min[a] : axis_min[a];
      base_max[a]      = in_q.start_req ? seed_max[a] : axis_max[a];
      axis_min_next[a] = base_min[a];
      axis_max_next[a] = base_max[a];
      if (!base_fin) begin
        if (smp[a] < base_min[a]) begin
          axis_min_next[a] = smp[a];
          widened          = 1'b1;
        end
        if (smp[a] > base_max[a]) begin
          axis_max_next[a] = smp[a];
          widened          = 1'b1;
        end
      end
    end
    last_change_ms_next = (!base_fin && widened) ? in_q.now_ms : base_last;
    // modulo 2^32 elapsed time since last widening
    elapsed       = in_q.now_ms - last_change_ms_next;
    finished_next = base_fin || (elapsed > timeout_ms);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int a = 0; a < NUM_AXES; a++) begin
        axis_min[a] <= SEED_MIN_RESET;
        axis_max[a] <= SEED_MAX_RESET;
      end
      last_change_ms <= '0;
      finished       <= 1'b0;
    end else if (fire) begin
      for (int a = 0; a < NUM_AXES; a++) begin
        axis_min[a] <= axis_min_next[a];
        axis_max[a] <= axis_max_next[a];
      end
      last_change_ms <= last_change_ms_next;
      finished       <= finished_next;
    end
  end

  // ---------------------------------------------------------------
  // Offsets and ranges from the updated bounds
  // ---------------------------------------------------------------
  wide_t   sum_w  [NUM_AXES];
  wide_t   sum_adj[NUM_AXES];
  wide_t   half_w [NUM_AXES];
  wide_t   rng_w  [NUM_AXES];

  always_comb begin
    for (int a = 0; a < NUM_AXES; a++) begin
      sum_w[a]   = wide_t'(axis_max_next[a]) + wide_t'(axis_min_next[a]);
      // add one to negative sums so the shift truncates toward zero
      sum_adj[a] = sum_w[a] + wide_t'({{(RANGE_W-1){1'b0}}, sum_w[a][RANGE_W-1]});
      half_w[a]  = sum_adj[a] >>> 1;
      rng_w[a]   = wide_t'(axis_max_next[a]) - wide_t'(axis_min_next[a]);
    end
  end

  // ---------------------------------------------------------------
  // Result register
  // ---------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= in_vld_q;
    end
    if (fire) begin
      done_res <= finished_next;
      changed  <= widened;
      offset_x <= half_w[0][SAMPLE_W-1:0];
      offset_y <= half_w[1][SAMPLE_W-1:0];
      offset_z <= half_w[2][SAMPLE_W-1:0];
      range_x  <= rng_w[0];
      range_y  <= rng_w[1];
      range_z  <= rng_w[2];
    end
  end

  // ---------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------
  // a widening sample restarts the timer, so it can never end calibration
  `MMCT_ASSERT_NOW(a_changed_not_done, clk, rst, out_valid && changed, !done_res,
    "widened request reported as done")
  // once finished, a request without start gives done and no change
  `MMCT_ASSERT_NEXT(a_done_sticky, clk, rst, fire && finished && !in_q.start_req,
    out_valid && done_res && !changed, "finished tracker changed or cleared done")
  // bounds are frozen after the end until a start request
  `MMCT_ASSERT_NEXT(a_bounds_frozen, clk, rst, finished && !(fire && in_q.start_req),
    $stable(axis_min[0]) && $stable(axis_max[0]) && $stable(axis_min[1]) &&
    $stable(axis_max[1]) && $stable(axis_min[2]) && $stable(axis_max[2]),
    "bounds moved after calibration ended")

endmodule

>>> test/axis_min_max_calibration_tracker_unit_checker.sv
`timescale 1ns / 1ps
// Checker for the min/max calibration tracker: predicts each result and compares it.
module axis_min_max_calibration_tracker_unit_checker
  import mmct_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  input  logic                  in_ready,
  input  logic                  start_req,
  input  sample_t               raw_x,
  input  sample_t               raw_y,
  input  sample_t               raw_z,
  input  logic [TIME_W-1:0]     now_ms,
  input  logic                  out_valid,
  input  logic                  out_ready,
  input  logic                  done_res,
  input  logic                  changed,
  input  sample_t               offset_x,
  input  sample_t               offset_y,
  input  sample_t               offset_z,
  input  wide_t                 range_x,
  input  wide_t                 range_y,
  input  wide_t                 range_z,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output int                    mismatches,
  output int                    outstanding
);

  typedef struct packed {
    logic                   done_res;
    logic                   changed;
    sample_t [NUM_AXES-1:0] offset;
    wide_t   [NUM_AXES-1:0] spread;
  } cal_result_t;

  // Register copies and tracker state
  logic [TIME_W-1:0] timeout_ms;
  int                seed_lo  [NUM_AXES];
  int                seed_hi  [NUM_AXES];
  int                bound_lo [NUM_AXES];
  int                bound_hi [NUM_AXES];
  logic [TIME_W-1:0] last_widen_ms;
  logic              cal_done;
  cal_result_t       predicted_results [$];
  cal_result_t       want;
  int                ax;

  // Advances the tracker by one sample and returns the result it gives.
  function automatic cal_result_t track_sample(input logic restart, input int sx, sy, sz,
                                               input logic [TIME_W-1:0] t);
    cal_result_t       r;
    int                s [NUM_AXES];
    logic              widened;
    logic [TIME_W-1:0] elapsed;
    int                a;
    s[0] = sx;
    s[1] = sy;
    s[2] = sz;
    widened = 1'b0;
    if (restart) begin
      bound_lo      = seed_lo;
      bound_hi      = seed_hi;
      last_widen_ms = '0;
      cal_done      = 1'b0;
    end
    // once finished, the bounds are frozen until the next restart
    if (!cal_done) begin
      for (a = 0; a < NUM_AXES; a++) begin
        if (s[a] < bound_lo[a]) begin
          bound_lo[a] = s[a];
          widened = 1'b1;
        end
        if (s[a] > bound_hi[a]) begin
          bound_hi[a] = s[a];
          widened = 1'b1;
        end
      end
      if (widened) last_widen_ms = t;
      elapsed = t - last_widen_ms;  // modulo 2^32
      if (elapsed > timeout_ms) cal_done = 1'b1;
    end
    r.done_res = cal_done;
    r.changed  = widened;
    for (a = 0; a < NUM_AXES; a++) begin
      r.offset[a] = SAMPLE_W'((bound_hi[a] + bound_lo[a]) / 2);  // truncates toward zero
      r.spread[a] = RANGE_W'(bound_hi[a] - bound_lo[a]);
    end
    return r;
  endfunction

  task automatic check_field(input string name, input logic signed [RANGE_W-1:0] exp_v,
                             input logic signed [RANGE_W-1:0] act_v);
    if (exp_v !== act_v) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, exp_v, act_v);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      timeout_ms    = TIMEOUT_RESET;
      for (ax = 0; ax < NUM_AXES; ax++) begin
        seed_lo[ax]  = SEED_MIN_RESET;
        seed_hi[ax]  = SEED_MAX_RESET;
        bound_lo[ax] = SEED_MIN_RESET;
        bound_hi[ax] = SEED_MAX_RESET;
      end
      last_widen_ms = '0;
      cal_done      = 1'b0;
      predicted_results.delete();
    end else begin
      if (out_valid && out_ready) begin
        if (predicted_results.size() == 0) begin
          $display("%0t: result with none expected, actual done %0d changed %0d",
                   $time, done_res, changed);
          mismatches++;
        end else begin
          want = predicted_results.pop_front();
          check_field("done_res", RANGE_W'(want.done_res), RANGE_W'(done_res));
          check_field("changed", RANGE_W'(want.changed), RANGE_W'(changed));
          check_field("offset_x", RANGE_W'(want.offset[0]), RANGE_W'(offset_x));
          check_field("offset_y", RANGE_W'(want.offset[1]), RANGE_W'(offset_y));
          check_field("offset_z", RANGE_W'(want.offset[2]), RANGE_W'(offset_z));
          check_field("range_x", want.spread[0], range_x);
          check_field("range_y", want.spread[1], range_y);
          check_field("range_z", want.spread[2], range_z);
        end
      end
      if (cfg_we) begin
        case (cfg_index)
          REG_TIMEOUT:    timeout_ms = cfg_data;
          REG_SEED_MIN_X: seed_lo[0] = $signed(cfg_data[SAMPLE_W-1:0]);
          REG_SEED_MAX_X: seed_hi[0] = $signed(cfg_data[SAMPLE_W-1:0]);
          REG_SEED_MIN_Y: seed_lo[1] = $signed(cfg_data[SAMPLE_W-1:0]);
          REG_SEED_MAX_Y: seed_hi[1] = $signed(cfg_data[SAMPLE_W-1:0]);
          REG_SEED_MIN_Z: seed_lo[2] = $signed(cfg_data[SAMPLE_W-1:0]);
          REG_SEED_MAX_Z: seed_hi[2] = $signed(cfg_data[SAMPLE_W-1:0]);
          default: ;
        endcase
      end
      if (in_valid && in_ready) begin
        predicted_results.push_back(track_sample(start_req, raw_x, raw_y, raw_z, now_ms));
      end
    end
    outstanding = predicted_results.size();
  end

endmodule

>>> test/axis_min_max_calibration_tracker_unit_test.sv
`timescale 1ns / 1ps
// Testbench top for the min/max calibration tracker: clock, reset, stimulus and verdict.
module axis_min_max_calibration_tracker_unit_test
  import mmct_pkg::*;
();

  // Index 7 lies past the register map; the block must drop the write.
  localparam logic [CFG_IDX_W-1:0] REG_UNMAPPED = 3'd7;
  localparam sample_t FULL_POS       = 16'sh7FFF;
  localparam sample_t FULL_NEG       = 16'sh8000;
  localparam int      RESET_CYCLES   = 2;
  // Two register stages between accept and result, plus margin.
  localparam int      SETTLE_CYCLES  = 4;
  localparam int      HOLD_CYCLES    = 40;
  localparam int      WATCHDOG_LIMIT = 2000;
  localparam int      PHASE_ITEMS    = 245;
  localparam int      SETTING_ITEMS  = 60;

  logic                  clk;
  logic                  rst;
  logic                  in_valid;
  logic                  in_ready;
  logic                  start_req;
  sample_t               raw_x;
  sample_t               raw_y;
  sample_t               raw_z;
  logic [TIME_W-1:0]     now_ms;
  logic                  out_valid;
  logic                  out_ready;
  logic                  done_res;
  logic                  changed;
  sample_t               offset_x;
  sample_t               offset_y;
  sample_t               offset_z;
  wide_t                 range_x;
  wide_t                 range_y;
  wide_t                 range_z;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;
  int                    mismatches;
  int                    outstanding;

  int                    send_idle_pct;
  int                    recv_idle_pct;
  logic                  hold_request;  // asks the result side for one long stall
  int                    quiet_cycles;
  logic [TIME_W-1:0]     cur_timeout;   // last timeout written, shapes the time steps

  axis_min_max_calibration_tracker_unit i_dut (.*);

  axis_min_max_calibration_tracker_unit_checker i_checker (.*);

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Result side: random backpressure, or a long hold when asked for one.
  // The hold is counted here so the sender keeps pushing and the pipeline fills.
  initial begin
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_request) begin
        hold_request = 1'b0;
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES - 1) begin
          @(negedge clk);
          out_ready <= 1'b0;
        end
      end else begin
        out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
      end
    end
  end

  // Watchdog: ends the run after a long stretch with no request moving on either side.
  initial begin
    quiet_cycles = 0;
    while (quiet_cycles < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready)) quiet_cycles = 0;
      else quiet_cycles++;
    end
    $display("Verification failed");
    $finish;
  end

  // Offers one sample request; returns at the falling edge after it was taken.
  // Random idle cycles go in front so gaps land anywhere in the pipeline.
  task automatic send_sample(input logic st, input sample_t x, y, z,
                             input logic [TIME_W-1:0] t);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid  <= 1'b1;
    start_req <= st;
    raw_x     <= x;
    raw_y     <= y;
    raw_z     <= z;
    now_ms    <= t;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
  endtask

  // Drops valid and waits until every predicted result has come out, then settles.
  task automatic wait_drained();
    in_valid <= 1'b0;
    do @(negedge clk); while (outstanding != 0);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // Write enable stays high across a batch; the caller lowers it after the last write.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] d);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= d;
    @(negedge clk);
  endtask

  // Seed writes carry random upper bits, which the block must ignore.
  task automatic program_config(input logic [TIME_W-1:0] tmo,
                                input sample_t lo_x, hi_x, lo_y, hi_y, lo_z, hi_z);
    write_reg(REG_TIMEOUT, tmo);
    write_reg(REG_SEED_MIN_X, {16'($urandom), lo_x});
    write_reg(REG_SEED_MAX_X, {16'($urandom), hi_x});
    write_reg(REG_SEED_MIN_Y, {16'($urandom), lo_y});
    write_reg(REG_SEED_MAX_Y, {16'($urandom), hi_y});
    write_reg(REG_SEED_MIN_Z, {16'($urandom), lo_z});
    write_reg(REG_SEED_MAX_Z, {16'($urandom), hi_z});
    write_reg(REG_UNMAPPED, $urandom);
    cfg_we <= 1'b0;
    cur_timeout = tmo;
  endtask

  task automatic program_random_config();
    logic [TIME_W-1:0] tmo;
    sample_t           lo [NUM_AXES];
    sample_t           hi [NUM_AXES];
    int                a;
    case ($urandom_range(0, 5))
      0:       tmo = '0;
      1:       tmo = '1;
      2:       tmo = $urandom;
      default: tmo = $urandom_range(8, 400);
    endcase
    // mostly the usual inverted full-scale seeds, sometimes arbitrary ones
    for (a = 0; a < NUM_AXES; a++) begin
      if ($urandom_range(0, 9) < 6) begin
        lo[a] = FULL_POS;
        hi[a] = FULL_NEG;
      end else begin
        lo[a] = 16'($urandom);
        hi[a] = 16'($urandom);
      end
    end
    program_config(tmo, lo[0], hi[0], lo[1], hi[1], lo[2], hi[2]);
  endtask

  // Near-uniform value within +/-amp, with an occasional full-scale extreme.
  function automatic sample_t pick_axis(input int amp);
    if ($urandom_range(0, 19) == 0) return $urandom_range(0, 1) ? FULL_POS : FULL_NEG;
    return SAMPLE_W'(int'($urandom_range(0, 2 * amp)) - amp);
  endfunction

  // One calibration run: a start request, then samples with advancing time.
  // New extremes get rarer as the run goes on; some steps jump to or past the
  // timeout so runs end, and a few requests are pure noise.
  task automatic run_session(input int len);
    int                amp;
    int                k;
    longint            reach;
    logic [TIME_W-1:0] t;
    case ($urandom_range(0, 2))
      0:       amp = 16;
      1:       amp = 1000;
      default: amp = 32767;
    endcase
    reach = (longint'(cur_timeout) * 3) / 4;
    if (reach < 3) reach = 3;
    if (reach > 1000000) reach = 1000000;
    // some runs begin just below the wrap of the millisecond counter
    if ($urandom_range(0, 4) == 0) t = 32'hFFFF_FFFF - 32'($urandom_range(0, 64));
    else t = $urandom;
    send_sample(1'b1, pick_axis(amp), pick_axis(amp), pick_axis(amp), t);
    for (k = 1; k < len; k++) begin
      if ($urandom_range(0, 99) < 8) begin
        send_sample(1'($urandom), 16'($urandom), 16'($urandom), 16'($urandom), $urandom);
      end else begin
        if ($urandom_range(0, 99) < 6) t = t + cur_timeout + 32'($urandom_range(0, 2));
        else t = t + 32'($urandom_range(0, int'(reach)));
        send_sample(1'b0, pick_axis(amp), pick_axis(amp), pick_axis(amp), t);
      end
    end
  endtask

  // Random phase: a fresh register setting every few dozen requests.
  task automatic run_random_phase(input int n_items);
    int left;
    int burst;
    int len;
    left = n_items;
    while (left > 0) begin
      wait_drained();
      program_random_config();
      burst = (left < SETTING_ITEMS) ? left : SETTING_ITEMS;
      left -= burst;
      while (burst > 0) begin
        len = $urandom_range(3, 30);
        if (len > burst) len = burst;
        run_session(len);
        burst -= len;
      end
    end
  endtask

  initial begin
    rst           = 1'b1;
    in_valid      = 1'b0;
    start_req     = 1'b0;
    raw_x         = '0;
    raw_y         = '0;
    raw_z         = '0;
    now_ms        = '0;
    cfg_we        = 1'b0;
    cfg_index     = '0;
    cfg_data      = '0;
    hold_request  = 1'b0;
    send_idle_pct = 25;
    recv_idle_pct = 52;
    cur_timeout   = TIMEOUT_RESET;
    repeat (RESET_CYCLES) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Reset settings: inverted full-scale seeds, 20000 ms timeout.
    send_sample(1'b1, 0, 0, 0, 5);                 // start, every bound widens
    send_sample(1'b0, FULL_NEG, FULL_POS, -1, 10);
    send_sample(1'b0, FULL_POS, FULL_NEG, 0, 20);  // x and y now full scale
    send_sample(1'b0, 100, -100, 0, 20020);        // gap equals the timeout: still running
    send_sample(1'b0, 0, 0, 0, 20021);             // one past: finished
    send_sample(1'b0, FULL_NEG, FULL_POS, 9, 20100);  // ignored, held bounds reported

    // Zero timeout; wide x seeds, inverted y seeds, equal z seeds.
    wait_drained();
    program_config('0, FULL_NEG, FULL_POS, 100, -100, 5, 5);
    send_sample(1'b0, 1, 2, 3, 30000);             // new seeds not loaded until start
    send_sample(1'b1, 0, 0, 5, 32'h1234);          // y widens both ways, x and z stay
    send_sample(1'b0, 0, 0, 5, 32'h1234);          // zero elapsed is not past zero
    send_sample(1'b0, 0, 0, 5, 32'h1235);          // finished

    // All seeds at full scale, so nothing can widen.
    wait_drained();
    program_config(32'd1000, FULL_NEG, FULL_POS, FULL_NEG, FULL_POS, FULL_NEG, FULL_POS);
    send_sample(1'b1, 3, -3, 0, 1001);             // first sample already past: ends at once
    send_sample(1'b1, 3, -3, 0, 1000);             // exactly at the timeout: keeps running

    // Elapsed time across the counter wrap.
    wait_drained();
    program_config(32'd100, FULL_POS, FULL_NEG, FULL_POS, FULL_NEG, FULL_POS, FULL_NEG);
    send_sample(1'b1, -7, 9, 1, 32'hFFFF_FFF0);
    send_sample(1'b0, -7, 9, 1, 32'h0000_0010);
    send_sample(1'b0, -7, 9, 1, 32'h0000_0054);    // exactly 100 after the start, across the wrap
    send_sample(1'b0, -7, 9, 1, 32'h0000_0055);    // finished

    // Largest timeout: even the longest gap never ends the run.
    wait_drained();
    program_config('1, FULL_POS, FULL_NEG, FULL_POS, FULL_NEG, FULL_POS, FULL_NEG);
    send_sample(1'b1, -1, -1, -1, 0);
    send_sample(1'b0, -1, -1, -1, 32'hFFFF_FFFF);

    run_random_phase(PHASE_ITEMS);

    wait_drained();
    send_idle_pct = 52;
    recv_idle_pct = 25;
    run_random_phase(PHASE_ITEMS);

    // No idling. First a long hold on the result side while requests keep coming,
    // so the pipeline fills and in_ready drops; then the sender waits for all of it.
    wait_drained();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    @(posedge clk);
    hold_request = 1'b1;
    @(negedge clk);
    run_session(12);
    wait_drained();
    run_random_phase(PHASE_ITEMS);

    wait_drained();
    if (mismatches == 0 && outstanding == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
